FILE: design/itok_pkg.sv
// itok_pkg: shared types, constants and helpers for the indentation-aware tokenizer
// used by itok_ctrl, itok_dp and indent_aware_tokenizer_unit; no dependencies
package itok_pkg;

  localparam int ITOK_STACK_DEPTH = 16;
  localparam int ITOK_INDENT_BITS = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  typedef enum logic [3:0] {
    TK_NEWLINE = 4'd0,
    TK_INDENT  = 4'd1,
    TK_DEDENT  = 4'd2,
    TK_IDENT   = 4'd3,
    TK_STRING  = 4'd4,
    TK_EQUALS  = 4'd5,
    TK_COMMA   = 4'd6,
    TK_EOF     = 4'd7,
    TK_ERROR   = 4'd8
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHAR     = 2'd1,
    ERR_UNTERM   = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_code_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      space_inc;
    logic      space_clr;
    logic      push;
    logic      pop;
    logic      drop;
    logic      emit;
    tok_kind_t kind;
    logic      with_char;
    logic      token_end;
    err_code_t err;
    logic      last;
  } itok_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic eoi;
    logic is_alnum;
    logic is_nl;
    logic is_space;
    logic is_quote;
    logic is_eq;
    logic is_comma;
    logic space_gt_top;
    logic top_gt_space;
    logic below_gt_space;
    logic lvl_gt1;
    logic lvl_gt2;
    logic lvl_full;
    logic slot_free;
  } itok_stat_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

FILE: design/indent_aware_tokenizer_unit.sv
// indent_aware_tokenizer_unit: top level, sequencer plus datapath
// depends on itok_pkg, itok_ctrl and itok_dp
//
//  channel  direction  handshake                 payload
//  byte     in         byte_valid / byte_ready   byte_value, end_of_input
//  token    out        token_valid / token_ready token_kind, char_value, char_valid,
//                                                token_end, error_code, last_in_run
//
// one item at a time: byte_ready is high only when idle, so no new byte is taken
// before the last one is through; an open identifier is closed first; once stopped,
// bytes give nothing; first real character of a line: an indent, an overflow error
// or dedents (the stack read is registered); end of input adds one dedent per open level
// a stalled token_ready holds the sequencer at its next result; ready drops meanwhile
// rst is synchronous; no clearing pass, the level stack needs none
module indent_aware_tokenizer_unit
  import itok_pkg::*;
#(
  parameter int STACK_DEPTH = ITOK_STACK_DEPTH,
  parameter int INDENT_BITS = ITOK_INDENT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  output logic       token_valid,
  input  logic       token_ready,
  output logic [3:0] token_kind,
  output logic [7:0] char_value,
  output logic       char_valid,
  output logic       token_end,
  output logic [1:0] error_code,
  output logic       last_in_run
);

  itok_cmd_t  cmd;
  itok_stat_t st;

  itok_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .st         (st),
    .cmd        (cmd)
  );

  itok_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .INDENT_BITS (INDENT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .byte_value   (byte_value),
    .end_of_input (end_of_input),
    .token_ready  (token_ready),
    .token_valid  (token_valid),
    .token_kind   (token_kind),
    .char_value   (char_value),
    .char_valid   (char_valid),
    .token_end    (token_end),
    .error_code   (error_code),
    .last_in_run  (last_in_run),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

FILE: design/itok_ctrl.sv
// itok_ctrl: sequencer for the tokenizer, one item at a time, one result per step
// depends on itok_pkg; drives itok_dp through itok_cmd_t and reads itok_stat_t
module itok_ctrl
  import itok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  itok_stat_t st,
  output itok_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CLOSE_ID,
    S_NORMAL,
    S_CHECK,
    S_INDENT,
    S_DED_WAIT,
    S_DEDENT,
    S_TOKEN,
    S_NEWLINE,
    S_STR,
    S_ERR,
    S_EOI_DED,
    S_EOF
  } state_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_IDENT,
    MODE_STRING,
    MODE_HALTED,
    MODE_FINISHED
  } mode_t;

  state_t    state, state_next;
  mode_t     scan_mode, scan_mode_next;
  logic      line_start, line_start_next;
  err_code_t err_sel, err_sel_next;

  assign byte_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    state_next      = state;
    scan_mode_next  = scan_mode;
    line_start_next = line_start;
    err_sel_next    = err_sel;
    unique case (state)
      S_IDLE: begin
        if (byte_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (scan_mode == MODE_HALTED || scan_mode == MODE_FINISHED) begin
          state_next = S_IDLE;
        end else if (st.eoi) begin
          if (scan_mode == MODE_STRING) begin
            err_sel_next = ERR_UNTERM;
            state_next   = S_ERR;
          end else if (scan_mode == MODE_IDENT) begin
            state_next = S_CLOSE_ID;
          end else begin
            state_next = S_EOI_DED;
          end
        end else if (scan_mode == MODE_STRING) begin
          state_next = S_STR;
        end else if (scan_mode == MODE_IDENT) begin
          state_next = st.is_alnum ? S_TOKEN : S_CLOSE_ID;
        end else begin
          state_next = S_NORMAL;
        end
      end
      S_CLOSE_ID: begin
        if (st.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = TK_IDENT;
          cmd.token_end  = 1'b1;
          // nothing else follows for a space or an opening quote
          cmd.last       = !st.eoi && (st.is_space || st.is_quote);
          scan_mode_next = MODE_NORMAL;
          state_next     = st.eoi ? S_EOI_DED : S_NORMAL;
        end
      end
      S_NORMAL: begin
        if (st.is_nl) begin
          state_next = S_NEWLINE;
        end else if (st.is_space) begin
          cmd.space_inc = line_start;
          state_next    = S_IDLE;
        end else if (!(st.is_alnum || st.is_quote || st.is_eq || st.is_comma)) begin
          err_sel_next = ERR_CHAR;
          state_next   = S_ERR;
        end else if (line_start) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_TOKEN;
        end
      end
      S_CHECK: begin
        line_start_next = 1'b0;
        if (st.space_gt_top) begin
          if (st.lvl_full) begin
            err_sel_next = ERR_OVERFLOW;
            state_next   = S_ERR;
          end else begin
            cmd.push   = 1'b1;
            state_next = S_INDENT;
          end
        end else begin
          state_next = S_DED_WAIT;
        end
      end
      S_INDENT: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = TK_INDENT;
          cmd.last   = st.is_quote;
          state_next = S_TOKEN;
        end
      end
      // lets the registered read of the level below the top settle
      S_DED_WAIT: begin
        state_next = S_DEDENT;
      end
      S_DEDENT: begin
        if (st.lvl_gt1 && st.top_gt_space) begin
          if (st.slot_free) begin
            cmd.emit   = 1'b1;
            cmd.kind   = TK_DEDENT;
            cmd.last   = st.is_quote && !(st.lvl_gt2 && st.below_gt_space);
            cmd.pop    = 1'b1;
            state_next = S_DED_WAIT;
          end
        end else begin
          state_next = S_TOKEN;
        end
      end
      S_TOKEN: begin
        if (st.is_quote) begin
          scan_mode_next = MODE_STRING;
          state_next     = S_IDLE;
        end else if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.with_char = st.is_alnum;
          cmd.last      = 1'b1;
          if (st.is_alnum) begin
            cmd.kind       = TK_IDENT;
            scan_mode_next = MODE_IDENT;
          end else if (st.is_eq) begin
            cmd.kind = TK_EQUALS;
          end else begin
            cmd.kind = TK_COMMA;
          end
          state_next = S_IDLE;
        end
      end
      S_NEWLINE: begin
        if (st.slot_free) begin
          cmd.emit        = 1'b1;
          cmd.kind        = TK_NEWLINE;
          cmd.last        = 1'b1;
          cmd.space_clr   = 1'b1;
          line_start_next = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_STR: begin
        if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = TK_STRING;
          cmd.with_char = !st.is_quote;
          cmd.token_end = st.is_quote;
          cmd.last      = 1'b1;
          if (st.is_quote) begin
            scan_mode_next = MODE_NORMAL;
          end
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (st.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = TK_ERROR;
          cmd.err        = err_sel;
          cmd.last       = 1'b1;
          scan_mode_next = MODE_HALTED;
          state_next     = S_IDLE;
        end
      end
      S_EOI_DED: begin
        if (st.lvl_gt1) begin
          if (st.slot_free) begin
            cmd.emit = 1'b1;
            cmd.kind = TK_DEDENT;
            cmd.drop = 1'b1;
          end
        end else begin
          state_next = S_EOF;
        end
      end
      S_EOF: begin
        if (st.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = TK_EOF;
          cmd.last       = 1'b1;
          scan_mode_next = MODE_FINISHED;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_mode  <= MODE_NORMAL;
      line_start <= 1'b1;
      err_sel    <= ERR_NONE;
    end else begin
      state      <= state_next;
      scan_mode  <= scan_mode_next;
      line_start <= line_start_next;
      err_sel    <= err_sel_next;
    end
  end

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.slot_free)
    else $error("result issued while the output register is occupied");

  a_no_result_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> !cmd.emit)
    else $error("result issued after the last result of an item");

  a_stack_single_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && (cmd.pop || cmd.drop)))
    else $error("push and pop in the same cycle");

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (scan_mode == MODE_HALTED || scan_mode == MODE_FINISHED) |-> !cmd.emit)
    else $error("result issued after error or end of file");

endmodule

FILE: design/itok_dp.sv
// itok_dp: item register, space counter, indent level stack and output register
// depends on itok_pkg; steered by itok_ctrl through itok_cmd_t
module itok_dp
  import itok_pkg::*;
#(
  parameter int STACK_DEPTH = ITOK_STACK_DEPTH,
  parameter int INDENT_BITS = ITOK_INDENT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  input  logic       token_ready,
  output logic       token_valid,
  output logic [3:0] token_kind,
  output logic [7:0] char_value,
  output logic       char_valid,
  output logic       token_end,
  output logic [1:0] error_code,
  output logic       last_in_run,
  input  itok_cmd_t  cmd,
  output itok_stat_t st
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);
  localparam logic [INDENT_BITS-1:0] COUNT_MAX = '1;

  logic [7:0]             cur_byte;
  logic                   cur_eoi;
  logic [INDENT_BITS-1:0] space_count;
  logic [INDENT_BITS-1:0] top_level;
  logic [INDENT_BITS-1:0] below_level;
  logic [LVL_W-1:0]       level_count;
  logic [LVL_W-1:0]       lvl_m1;
  logic [LVL_W-1:0]       lvl_m2;

  // levels under the top; the top itself is kept in top_level
  logic [INDENT_BITS-1:0] stack_mem [STACK_DEPTH];

  assign lvl_m1 = level_count - LVL_W'(1);
  assign lvl_m2 = level_count - LVL_W'(2);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_byte <= byte_value;
      cur_eoi  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_count <= '0;
    end else if (cmd.space_clr) begin
      space_count <= '0;
    end else if (cmd.space_inc && space_count != COUNT_MAX) begin
      space_count <= space_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LVL_W'(1);
      top_level   <= '0;
    end else if (cmd.push) begin
      level_count <= level_count + 1'b1;
      top_level   <= space_count;
    end else if (cmd.pop) begin
      level_count <= lvl_m1;
      top_level   <= below_level;
    end else if (cmd.drop) begin
      level_count <= lvl_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[lvl_m1[AW-1:0]] <= top_level;
    end
    below_level <= stack_mem[lvl_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (cmd.emit) begin
      token_valid <= 1'b1;
    end else if (token_ready) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      token_kind  <= cmd.kind;
      char_value  <= cmd.with_char ? cur_byte : 8'h00;
      char_valid  <= cmd.with_char;
      token_end   <= cmd.token_end;
      error_code  <= cmd.err;
      last_in_run <= cmd.last;
    end
  end

  always_comb begin
    st.eoi            = cur_eoi;
    st.is_alnum       = is_alnum(cur_byte);
    st.is_nl          = (cur_byte == CH_NEWLINE);
    st.is_space       = (cur_byte == CH_SPACE);
    st.is_quote       = (cur_byte == CH_QUOTE);
    st.is_eq          = (cur_byte == CH_EQUALS);
    st.is_comma       = (cur_byte == CH_COMMA);
    st.space_gt_top   = (space_count > top_level);
    st.top_gt_space   = (top_level > space_count);
    st.below_gt_space = (below_level > space_count);
    st.lvl_gt1        = (level_count > LVL_W'(1));
    st.lvl_gt2        = (level_count > LVL_W'(2));
    st.lvl_full       = (level_count >= LVL_W'(STACK_DEPTH));
    st.slot_free      = !token_valid || token_ready;
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level_count != '0 && level_count <= LVL_W'(STACK_DEPTH))
    else $error("indent level count out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> level_count == $past(level_count) + 1'b1 &&
                 top_level == $past(space_count))
    else $error("push did not take the space count");

  a_pop_shallower: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> top_level < $past(top_level))
    else $error("pop did not expose a shallower level");

endmodule

FILE: bench/token_checker.sv
`timescale 1ns / 100ps
// token_checker: watches the byte and token channels of the indentation-aware tokenizer,
// predicts the token stream from each accepted byte and compares every accepted token
// depends on itok_pkg only
module token_checker
  import itok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  logic [7:0] byte_value,
  input  logic       end_of_input,
  input  logic       token_valid,
  input  logic       token_ready,
  input  logic [3:0] token_kind,
  input  logic [7:0] char_value,
  input  logic       char_valid,
  input  logic       token_end,
  input  logic [1:0] error_code,
  input  logic       last_in_run,
  output int         fail_count,
  output int         pending_count,
  output int         token_count
);

  typedef enum logic [2:0] {
    LX_PLAIN,
    LX_WORD,
    LX_QUOTED,
    LX_HALTED,
    LX_FINISHED
  } lex_mode_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] ch;
    logic       ch_ok;
    logic       closes;
    err_code_t  err;
    logic       last;
  } token_t;

  lex_mode_t                   mode;
  logic                        line_fresh;
  logic [ITOK_INDENT_BITS-1:0] lead_spaces;
  logic [ITOK_INDENT_BITS-1:0] levels [ITOK_STACK_DEPTH];
  int                          depth;
  token_t                      expected_tokens [$];
  int                          step_tokens;
  int                          mismatches = 0;
  int                          compared = 0;

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void emit(input tok_kind_t k, input logic [7:0] c, input logic c_ok,
                               input logic ends, input err_code_t e);
    token_t t;
    t = '{kind: k, ch: c, ch_ok: c_ok, closes: ends, err: e, last: 1'b0};
    expected_tokens.push_back(t);
    step_tokens++;
  endfunction

  task automatic report(input string field, input int got, input int want);
    $display("mismatch at token %0d: %s got %0d expected %0d", compared, field, got, want);
    mismatches++;
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic eoi);
    logic [ITOK_INDENT_BITS-1:0] top;
    logic                        blocked;
    token_t                      t;
    step_tokens = 0;
    blocked = 1'b0;
    if (mode == LX_HALTED || mode == LX_FINISHED) return;
    if (eoi) begin
      if (mode == LX_QUOTED) begin
        emit(TK_ERROR, 8'h00, 1'b0, 1'b0, ERR_UNTERM);
        mode = LX_HALTED;
      end else begin
        if (mode == LX_WORD) emit(TK_IDENT, 8'h00, 1'b0, 1'b1, ERR_NONE);
        while (depth > 1) begin
          depth--;
          emit(TK_DEDENT, 8'h00, 1'b0, 1'b0, ERR_NONE);
        end
        emit(TK_EOF, 8'h00, 1'b0, 1'b0, ERR_NONE);
        mode = LX_FINISHED;
      end
    end else if (mode == LX_QUOTED) begin
      // a newline in here is just another character
      if (c == CH_QUOTE) begin
        emit(TK_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
        mode = LX_PLAIN;
      end else begin
        emit(TK_STRING, c, 1'b1, 1'b0, ERR_NONE);
      end
    end else if (mode == LX_WORD && word_char(c)) begin
      emit(TK_IDENT, c, 1'b1, 1'b0, ERR_NONE);
    end else begin
      if (mode == LX_WORD) begin
        emit(TK_IDENT, 8'h00, 1'b0, 1'b1, ERR_NONE);
        mode = LX_PLAIN;
      end
      if (c == CH_NEWLINE) begin
        emit(TK_NEWLINE, 8'h00, 1'b0, 1'b0, ERR_NONE);
        line_fresh = 1'b1;
        lead_spaces = '0;
      end else if (c == CH_SPACE) begin
        if (line_fresh && lead_spaces != '1) lead_spaces++;
      end else if (!word_char(c) && c != CH_QUOTE && c != CH_EQUALS && c != CH_COMMA) begin
        emit(TK_ERROR, 8'h00, 1'b0, 1'b0, ERR_CHAR);
        mode = LX_HALTED;
      end else begin
        if (line_fresh) begin
          top = levels[depth-1];
          line_fresh = 1'b0;
          if (lead_spaces > top) begin
            if (depth >= ITOK_STACK_DEPTH) begin
              emit(TK_ERROR, 8'h00, 1'b0, 1'b0, ERR_OVERFLOW);
              mode = LX_HALTED;
              blocked = 1'b1;
            end else begin
              levels[depth] = lead_spaces;
              depth++;
              emit(TK_INDENT, 8'h00, 1'b0, 1'b0, ERR_NONE);
            end
          end else begin
            // pop until the top is no deeper than this line
            while (depth > 1 && levels[depth-1] > lead_spaces) begin
              depth--;
              emit(TK_DEDENT, 8'h00, 1'b0, 1'b0, ERR_NONE);
            end
          end
        end
        if (!blocked) begin
          if (word_char(c)) begin
            emit(TK_IDENT, c, 1'b1, 1'b0, ERR_NONE);
            mode = LX_WORD;
          end else if (c == CH_QUOTE) begin
            mode = LX_QUOTED;
          end else if (c == CH_EQUALS) begin
            emit(TK_EQUALS, 8'h00, 1'b0, 1'b0, ERR_NONE);
          end else begin
            emit(TK_COMMA, 8'h00, 1'b0, 1'b0, ERR_NONE);
          end
        end
      end
    end
    if (step_tokens > 0) begin
      t = expected_tokens.pop_back();
      t.last = 1'b1;
      expected_tokens.push_back(t);
    end
  endtask

  task automatic check_token();
    token_t want;
    compared++;
    if (expected_tokens.size() == 0) begin
      report("token_kind (nothing expected)", int'(token_kind), -1);
      return;
    end
    want = expected_tokens.pop_front();
    if (token_kind != want.kind) report("token_kind", int'(token_kind), int'(want.kind));
    if (char_value != want.ch) report("char_value", int'(char_value), int'(want.ch));
    if (char_valid != want.ch_ok) report("char_valid", int'(char_valid), int'(want.ch_ok));
    if (token_end != want.closes) report("token_end", int'(token_end), int'(want.closes));
    if (error_code != want.err) report("error_code", int'(error_code), int'(want.err));
    if (last_in_run != want.last) report("last_in_run", int'(last_in_run), int'(want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode = LX_PLAIN;
      line_fresh = 1'b1;
      lead_spaces = '0;
      depth = 1;
      foreach (levels[i]) levels[i] = '0;
      expected_tokens.delete();
    end else begin
      if (byte_valid && byte_ready) lex_byte(byte_value, end_of_input);
      if (token_valid && token_ready) check_token();
    end
    fail_count <= mismatches;
    pending_count <= expected_tokens.size();
    token_count <= compared;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: top level for the indentation-aware tokenizer; feeds source text byte by byte,
// pulls tokens with random stalls and gives the verdict; depends on itok_pkg, the design
// and token_checker
module testbench
  import itok_pkg::*;
();

  localparam int RANDOM_ITEMS = 250;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 80;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic [7:0] byte_value = 8'h00;
  logic       end_of_input = 1'b0;
  logic       token_ready = 1'b0;
  logic       byte_ready;
  logic       token_valid;
  logic [3:0] token_kind;
  logic [7:0] char_value;
  logic       char_valid;
  logic       token_end;
  logic [1:0] error_code;
  logic       last_in_run;

  int    fail_count;
  int    pending_count;
  int    token_count;
  int    items_sent = 0;
  int    idle_cycles = 0;
  string ending = "none";

  always #2 clk = ~clk;

  indent_aware_tokenizer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_value   (byte_value),
    .end_of_input (end_of_input),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .char_value   (char_value),
    .char_valid   (char_valid),
    .token_end    (token_end),
    .error_code   (error_code),
    .last_in_run  (last_in_run)
  );

  token_checker i_token_check (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_ready    (byte_ready),
    .byte_value    (byte_value),
    .end_of_input  (end_of_input),
    .token_valid   (token_valid),
    .token_ready   (token_ready),
    .token_kind    (token_kind),
    .char_value    (char_value),
    .char_valid    (char_valid),
    .token_end     (token_end),
    .error_code    (error_code),
    .last_in_run   (last_in_run),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .token_count   (token_count)
  );

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (token_valid && token_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  // anything but the closing quote, newlines favoured now and then
  function automatic logic [7:0] pick_string_byte();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return CH_NEWLINE;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
    return b;
  endfunction

  function automatic logic [7:0] stray_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h09;
      2:       return 8'($urandom_range(8'h80, 8'hFF));
      3:       return 8'($urandom_range(8'h01, 8'h08));
      4:       return 8'h21;
      default: return 8'h5F;
    endcase
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    byte_value <= b;
    end_of_input <= eoi;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // leading spaces then a few tokens with random spacing between them
  task automatic send_line(input int indent, input logic close_line);
    int parts;
    repeat (indent) send_item(CH_SPACE, 1'b0);
    parts = $urandom_range(1, 4);
    for (int p = 0; p < parts; p++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: repeat ($urandom_range(1, 6)) send_item(pick_alnum(), 1'b0);
        3: begin
          send_item(CH_QUOTE, 1'b0);
          repeat ($urandom_range(0, 5)) send_item(pick_string_byte(), 1'b0);
          send_item(CH_QUOTE, 1'b0);
        end
        4:       send_item(CH_EQUALS, 1'b0);
        default: send_item(CH_COMMA, 1'b0);
      endcase
      repeat ($urandom_range(0, 2)) send_item(CH_SPACE, 1'b0);
    end
    if (close_line) send_item(CH_NEWLINE, 1'b0);
  endtask

  initial begin : token_sink
    int   hold_at;
    int   n;
    logic held;
    held = 1'b0;
    // lands inside the random lines, where most bytes give tokens
    hold_at = $urandom_range(400, 520);
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      token_ready <= 1'b1;
      n = $urandom_range(1, 24);
      repeat (n) @(posedge clk);
      if (!held && items_sent >= hold_at) begin
        // long hold-off so the tokenizer backs up and stops taking bytes
        held = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = pick_gap();
      end
      if (n > 0) begin
        token_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : byte_source
    int target;
    int indent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // identifiers, equals, strings holding newline and extreme bytes, empty string, comma,
    // blank line, indents, dedent to an unknown column, dedent back to column zero
    send_text("aZ9 =\"\n");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("\",\"\"\n\n  q,\n    y\n   m\nk\n");

    // indent count runs into saturation
    send_line(300, 1'b1);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(0, 3)) send_item(CH_SPACE, 1'b0);
        send_item(CH_NEWLINE, 1'b0);
      end else begin
        indent = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
        send_line(indent, 1'b1);
      end
    end

    // one way of closing the stream per run
    case ($urandom_range(0, 3))
      0: begin
        ending = "end of input";
        if ($urandom_range(0, 1) == 1) send_line($urandom_range(0, 14), 1'b0);
        send_item(8'($urandom), 1'b1);
      end
      1: begin
        ending = "unexpected character";
        repeat ($urandom_range(0, 3)) send_item(pick_alnum(), 1'b0);
        send_item(stray_byte(), 1'b0);
      end
      2: begin
        ending = "unterminated string";
        send_item(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) send_item(pick_string_byte(), 1'b0);
        send_item(8'($urandom), 1'b1);
      end
      default: begin
        ending = "indent stack overflow";
        send_line(0, 1'b1);
        for (int k = 1; k <= ITOK_STACK_DEPTH; k++) send_line(k, 1'b1);
      end
    endcase

    // block is stopped now, these must give nothing
    send_item(8'($urandom), 1'b1);
    repeat (2) send_item(8'($urandom), 1'($urandom));
    byte_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d source bytes in, %0d tokens compared", items_sent, token_count);
    $display("run: stream closed by %s", ending);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/itok_pkg.sv
design/itok_ctrl.sv
design/itok_dp.sv
design/indent_aware_tokenizer_unit.sv
bench/token_checker.sv
bench/testbench.sv
